[hw/rtl/mrc_pkg.sv]
// ============================================================================
// mrc_pkg - shared types and codes of the perceptron risk classifier
// Sequencer states, layer codes, operation kinds and the control word that
// travels with each operation through the multiply-accumulate pipeline.
// ============================================================================
package mrc_pkg;

    // Neuron or class index carried in the control word; covers 64 neurons
    localparam int IDX_W = 6;

    // Action codes of an input word
    localparam logic ACT_WRITE    = 1'b0;
    localparam logic ACT_CLASSIFY = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_TEMP_MEAN = 2'd0;
    localparam logic [1:0] CFG_TEMP_INV  = 2'd1;
    localparam logic [1:0] CFG_HUM_MEAN  = 2'd2;
    localparam logic [1:0] CFG_HUM_INV   = 2'd3;

    // One in Q4.12: turns a Q8.8 bias into a Q.20 accumulator start value
    localparam logic signed [16:0] Q12_ONE = 17'sd4096;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_NWAIT,
        ST_LAYER,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        LY_FIRST,
        LY_SECOND,
        LY_OUTPUT
    } t_layer;

    typedef enum logic [1:0] {
        OP_NORM,
        OP_BIAS,
        OP_MAC
    } t_kind;

    // Control word of one multiply-accumulate operation
    typedef struct packed {
        logic             valid;
        t_kind            kind;
        logic             last;    // closes a neuron or a normalisation
        logic             relu;    // clamp negatives of the closed neuron
        logic             wr_act;  // store the result in the activation RAM
        logic             score;   // feed the result to the argmax
        logic             bank;    // destination activation bank
        logic [IDX_W-1:0] idx;     // neuron, class or input index
    } t_op;

endpackage

[hw/rtl/mlp_risk_classifier_unit.sv]
// ============================================================================
// mlp_risk_classifier_unit - fixed-point perceptron risk classifier
// Normalises a temperature/humidity pair and runs it through a
// NUM_INPUTS-HIDDEN_WIDTH-HIDDEN_WIDTH-NUM_CLASSES perceptron on one shared
// multiply-accumulate unit; returns the argmax class. Write words load the
// coefficient store.
// ============================================================================
//
//  channel   handshake          payload
//  -------   ----------------   ---------------------------------------------
//  input     i_valid / o_ready  i_action, i_coef_index, i_coef_value,
//                               i_temperature, i_humidity
//  output    o_valid / i_ready  o_risk_class
//  config    i_cfg_we           i_cfg_idx, i_cfg_data (no wait, no read-back)
//
//  A write word is taken only while idle and stores one coefficient. A classify
//  word runs the normalisation and then each layer, neuron by neuron, through
//  the shared multiply-accumulate unit, which retires one product per cycle
//  while steps are issued; a drain of its three-stage pipeline follows the
//  normalisation and each layer, and a finish state hands over the result.
//  Reset clears control only; the coefficient store is undefined until
//  written and gets no clearing pass.
//  A finished result waits in the output register while new words are taken;
//  a following classify then holds in its last step until the register frees.
//
module mlp_risk_classifier_unit
    import mrc_pkg::*;
#(
    parameter int HIDDEN_WIDTH = 8,
    parameter int NUM_CLASSES  = 3,
    parameter int NUM_INPUTS   = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_action,
    input  logic [6:0]         i_coef_index,
    input  logic signed [15:0] i_coef_value,
    input  logic signed [15:0] i_temperature,
    input  logic signed [15:0] i_humidity,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_risk_class,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data
);

    localparam int STORE_DEPTH = NUM_INPUTS * HIDDEN_WIDTH + HIDDEN_WIDTH
                               + HIDDEN_WIDTH * HIDDEN_WIDTH + HIDDEN_WIDTH
                               + HIDDEN_WIDTH * NUM_CLASSES + NUM_CLASSES;
    localparam int CAW       = $clog2(STORE_DEPTH);
    localparam int MAXW_A    = (NUM_INPUTS > HIDDEN_WIDTH) ? NUM_INPUTS : HIDDEN_WIDTH;
    localparam int MAXW      = (MAXW_A > NUM_CLASSES) ? MAXW_A : NUM_CLASSES;
    localparam int AI        = $clog2(MAXW);
    localparam int ACT_DEPTH = 2 ** (AI + 1);
    localparam int CLS_W     = $clog2(NUM_CLASSES);
    localparam int MAX_IN    = (NUM_INPUTS > HIDDEN_WIDTH) ? NUM_INPUTS : HIDDEN_WIDTH;

    logic signed [15:0] r_temp_mean;
    logic signed [15:0] r_temp_inv;
    logic signed [15:0] r_hum_mean;
    logic signed [15:0] r_hum_inv;
    logic signed [15:0] r_temp;
    logic signed [15:0] r_hum;
    logic signed [15:0] r_best;
    logic [CLS_W-1:0]   r_best_idx;
    logic               r_out_valid;
    logic [1:0]         r_out_class;

    logic               w_in_acc;
    logic               w_start;
    logic               w_coef_we;
    logic               w_busy;
    logic               w_out_free;
    logic               w_finish;
    t_op                w_tok_issue;
    t_op                w_tok3;
    logic [CAW-1:0]     w_coef_raddr;
    logic [AI:0]        w_act_raddr;
    logic signed [15:0] w_coef_rdata;
    logic signed [15:0] w_act_rdata;
    logic signed [15:0] w_y;
    logic               w_act_we;
    logic               w_score_en;
    logic [CLS_W-1:0]   w_cls;

    assign w_in_acc   = i_valid && o_ready;
    assign w_start    = w_in_acc && (i_action == ACT_CLASSIFY);
    assign w_coef_we  = w_in_acc && (i_action == ACT_WRITE)
                        && (int'(i_coef_index) < STORE_DEPTH);
    assign w_out_free = !r_out_valid || i_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_mean <= 16'sd0;
            r_temp_inv  <= 16'sd4096;
            r_hum_mean  <= 16'sd0;
            r_hum_inv   <= 16'sd4096;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TEMP_MEAN: r_temp_mean <= i_cfg_data;
                CFG_TEMP_INV:  r_temp_inv  <= i_cfg_data;
                CFG_HUM_MEAN:  r_hum_mean  <= i_cfg_data;
                CFG_HUM_INV:   r_hum_inv   <= i_cfg_data;
                default:       r_temp_mean <= r_temp_mean;
            endcase
        end
    end

    // Capture the sample pair of a classify word
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_temp <= i_temperature;
            r_hum  <= i_humidity;
        end
    end

    mrc_ram #(
        .WIDTH (16),
        .DEPTH (STORE_DEPTH)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_coef_we),
        .i_waddr (CAW'(i_coef_index)),
        .i_wdata (i_coef_value),
        .i_raddr (w_coef_raddr),
        .o_rdata (w_coef_rdata)
    );

    mrc_seq #(
        .HIDDEN_WIDTH (HIDDEN_WIDTH),
        .NUM_CLASSES  (NUM_CLASSES),
        .NUM_INPUTS   (NUM_INPUTS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_start),
        .i_busy       (w_busy),
        .i_out_free   (w_out_free),
        .o_ready      (o_ready),
        .o_finish     (w_finish),
        .o_tok        (w_tok_issue),
        .o_coef_raddr (w_coef_raddr),
        .o_act_raddr  (w_act_raddr)
    );

    mrc_mac #(
        .MAX_IN (MAX_IN)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok       (w_tok_issue),
        .i_coef      (w_coef_rdata),
        .i_act       (w_act_rdata),
        .i_temp      (r_temp),
        .i_hum       (r_hum),
        .i_temp_mean (r_temp_mean),
        .i_temp_inv  (r_temp_inv),
        .i_hum_mean  (r_hum_mean),
        .i_hum_inv   (r_hum_inv),
        .o_tok       (w_tok3),
        .o_y         (w_y),
        .o_busy      (w_busy)
    );

    // Store closed neurons into the destination activation bank
    assign w_act_we = w_tok3.valid && w_tok3.last && w_tok3.wr_act;

    mrc_ram #(
        .WIDTH (16),
        .DEPTH (ACT_DEPTH)
    ) u_act_ram (
        .i_clk   (i_clk),
        .i_we    (w_act_we),
        .i_waddr ({w_tok3.bank, AI'(w_tok3.idx)}),
        .i_wdata (w_y),
        .i_raddr (w_act_raddr),
        .o_rdata (w_act_rdata)
    );

    // Running argmax over output scores; the lowest index keeps ties
    assign w_score_en = w_tok3.valid && w_tok3.last && w_tok3.score;
    assign w_cls      = CLS_W'(w_tok3.idx);

    always_ff @(posedge i_clk) begin
        if (w_score_en && ((w_cls == '0) || (w_y > r_best))) begin
            r_best     <= w_y;
            r_best_idx <= w_cls;
        end
    end

    // Output register: hold the word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out_class <= 2'(r_best_idx);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_risk_class = r_out_class;

`ifndef SYNTHESIS
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !w_busy)
        else $error("word taken while the MAC pipeline still holds work");

    a_start_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> !o_ready)
        else $error("classify word did not close the input");

    a_score_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_score_en |-> !o_ready)
        else $error("output score retired while the sequencer was idle");

    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (int'(o_risk_class) < NUM_CLASSES))
        else $error("class index beyond the class count");

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |-> w_out_free)
        else $error("result overwrote a word not yet taken");
`endif

endmodule

[hw/rtl/mrc_ram.sv]
// ============================================================================
// mrc_ram - generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
module mrc_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 128,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/mrc_mac.sv]
// ============================================================================
// mrc_mac - shared multiply-accumulate unit
// Selects operands, multiplies, accumulates in Q.20 and rounds the closed
// sum down to a saturated Q8.8 value with optional ReLU. Three stages.
// ============================================================================
module mrc_mac
    import mrc_pkg::*;
#(
    parameter int MAX_IN = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_op                i_tok,
    input  logic signed [15:0] i_coef,
    input  logic signed [15:0] i_act,
    input  logic signed [15:0] i_temp,
    input  logic signed [15:0] i_hum,
    input  logic signed [15:0] i_temp_mean,
    input  logic signed [15:0] i_temp_inv,
    input  logic signed [15:0] i_hum_mean,
    input  logic signed [15:0] i_hum_inv,
    output t_op                o_tok,
    output logic signed [15:0] o_y,
    output logic               o_busy
);

    // Product 33 bits, plus headroom for MAX_IN products and the bias
    localparam int ACC_W = 34 + $clog2(MAX_IN + 1);
    localparam int QW    = ACC_W - 12;

    t_op                     r_tok1;
    t_op                     r_tok2;
    t_op                     r_tok3;
    logic signed [16:0]      w_a;
    logic signed [15:0]      w_b;
    logic signed [32:0]      r_prod;
    logic signed [ACC_W-1:0] w_prod_ext;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [QW-1:0]    w_q;
    logic signed [15:0]      w_sat;

    // Advance the control words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok1 <= '0;
            r_tok2 <= '0;
            r_tok3 <= '0;
        end else begin
            r_tok1 <= i_tok;
            r_tok2 <= r_tok1;
            r_tok3 <= r_tok2;
        end
    end

    // Pick operands: centred sample by inverse scale, bias by one, or act by weight
    always_comb begin
        w_a = '0;
        w_b = i_coef;
        case (r_tok1.kind)
            OP_NORM: begin
                if (r_tok1.idx == IDX_W'(0)) begin
                    w_a = {i_temp[15], i_temp} - {i_temp_mean[15], i_temp_mean};
                    w_b = i_temp_inv;
                end else if (r_tok1.idx == IDX_W'(1)) begin
                    w_a = {i_hum[15], i_hum} - {i_hum_mean[15], i_hum_mean};
                    w_b = i_hum_inv;
                end else begin
                    // inputs beyond the sample pair read as zero
                    w_b = '0;
                end
            end
            OP_BIAS: begin
                w_a = Q12_ONE;
            end
            OP_MAC: begin
                w_a = {i_act[15], i_act};
            end
            default: begin
                w_a = '0;
            end
        endcase
    end

    // Multiply
    always_ff @(posedge i_clk) begin
        r_prod <= w_a * w_b;
    end

    // Accumulate; a bias or normalisation restarts the sum
    assign w_prod_ext = ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (r_tok2.kind != OP_MAC) begin
            r_acc <= w_prod_ext;
        end else begin
            r_acc <= r_acc + w_prod_ext;
        end
    end

    // Floor by 4096, saturate to 16 bits, then ReLU
    assign w_q = r_acc[ACC_W-1:12];

    always_comb begin
        if ((&w_q[QW-1:15]) || !(|w_q[QW-1:15])) begin
            w_sat = w_q[15:0];
        end else if (w_q[QW-1]) begin
            w_sat = 16'sh8000;
        end else begin
            w_sat = 16'sh7FFF;
        end
        if (r_tok3.relu && w_sat[15]) begin
            o_y = '0;
        end else begin
            o_y = w_sat;
        end
    end

    assign o_tok  = r_tok3;
    assign o_busy = r_tok1.valid || r_tok2.valid || r_tok3.valid;

endmodule

[hw/rtl/mrc_seq.sv]
// ============================================================================
// mrc_seq - operation sequencer
// Walks normalisation, then each layer neuron by neuron: one bias step and
// one weight step per input, issuing one operation per cycle to the MAC within
// the normalisation and each layer, and waiting for the MAC to drain between them.
module mrc_seq
    import mrc_pkg::*;
#(
    parameter  int HIDDEN_WIDTH = 8,
    parameter  int NUM_CLASSES  = 3,
    parameter  int NUM_INPUTS   = 2,
    localparam int OFS_W1       = 0,
    localparam int OFS_B1       = OFS_W1 + NUM_INPUTS * HIDDEN_WIDTH,
    localparam int OFS_W2       = OFS_B1 + HIDDEN_WIDTH,
    localparam int OFS_B2       = OFS_W2 + HIDDEN_WIDTH * HIDDEN_WIDTH,
    localparam int OFS_W3       = OFS_B2 + HIDDEN_WIDTH,
    localparam int OFS_B3       = OFS_W3 + HIDDEN_WIDTH * NUM_CLASSES,
    localparam int STORE_DEPTH  = OFS_B3 + NUM_CLASSES,
    localparam int CAW          = $clog2(STORE_DEPTH),
    localparam int MAXW_A       = (NUM_INPUTS > HIDDEN_WIDTH) ? NUM_INPUTS : HIDDEN_WIDTH,
    localparam int MAXW         = (MAXW_A > NUM_CLASSES) ? MAXW_A : NUM_CLASSES,
    localparam int AI           = $clog2(MAXW)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_busy,
    input  logic          i_out_free,
    output logic          o_ready,
    output logic          o_finish,
    output t_op           o_tok,
    output logic [CAW-1:0] o_coef_raddr,
    output logic [AI:0]   o_act_raddr
);

    localparam int CNT_W = $clog2(MAXW + 1);

    t_state           r_state, n_state;
    t_layer           r_layer, n_layer;
    logic [CNT_W-1:0] r_j, n_j;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CAW-1:0]   r_waddr, n_waddr;

    logic [CNT_W-1:0] w_nin;
    logic [CNT_W-1:0] w_nout;
    logic [CAW-1:0]   w_wofs;
    logic [CAW-1:0]   w_bofs;
    logic             w_relu;
    logic             w_src;
    logic             w_dst;
    logic             w_score;
    logic [CNT_W-1:0] w_i_m1;
    logic             w_last;

    // Hold sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_layer <= LY_FIRST;
            r_j     <= '0;
            r_i     <= '0;
        end else begin
            r_state <= n_state;
            r_layer <= n_layer;
            r_j     <= n_j;
            r_i     <= n_i;
        end
    end

    always_ff @(posedge i_clk) begin
        r_waddr <= n_waddr;
    end

    // Shape of the current layer
    always_comb begin
        case (r_layer)
            LY_SECOND: begin
                w_nin   = CNT_W'(HIDDEN_WIDTH);
                w_nout  = CNT_W'(HIDDEN_WIDTH);
                w_wofs  = CAW'(OFS_W2);
                w_bofs  = CAW'(OFS_B2);
                w_relu  = 1'b1;
                w_src   = 1'b1;
                w_dst   = 1'b0;
                w_score = 1'b0;
            end
            LY_OUTPUT: begin
                w_nin   = CNT_W'(HIDDEN_WIDTH);
                w_nout  = CNT_W'(NUM_CLASSES);
                w_wofs  = CAW'(OFS_W3);
                w_bofs  = CAW'(OFS_B3);
                w_relu  = 1'b0;
                w_src   = 1'b0;
                w_dst   = 1'b0;
                w_score = 1'b1;
            end
            default: begin
                w_nin   = CNT_W'(NUM_INPUTS);
                w_nout  = CNT_W'(HIDDEN_WIDTH);
                w_wofs  = CAW'(OFS_W1);
                w_bofs  = CAW'(OFS_B1);
                w_relu  = 1'b1;
                w_src   = 1'b0;
                w_dst   = 1'b1;
                w_score = 1'b0;
            end
        endcase
    end

    assign w_i_m1 = r_i - CNT_W'(1);
    assign w_last = (r_i == w_nin);

    // Next state and issued operation
    always_comb begin
        n_state      = r_state;
        n_layer      = r_layer;
        n_j          = r_j;
        n_i          = r_i;
        n_waddr      = r_waddr;
        o_ready      = 1'b0;
        o_finish     = 1'b0;
        o_tok        = '0;
        o_coef_raddr = r_waddr;
        o_act_raddr  = {w_src, AI'(w_i_m1)};
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_start) begin
                    n_state = ST_NORM;
                    n_j     = '0;
                end
            end
            ST_NORM: begin
                o_tok.valid  = 1'b1;
                o_tok.kind   = OP_NORM;
                o_tok.last   = 1'b1;
                o_tok.wr_act = 1'b1;
                o_tok.bank   = 1'b0;
                o_tok.idx    = IDX_W'(r_j);
                if (r_j == CNT_W'(NUM_INPUTS - 1)) begin
                    n_j     = '0;
                    n_state = ST_NWAIT;
                end else begin
                    n_j = r_j + CNT_W'(1);
                end
            end
            ST_NWAIT: begin
                // wait for the inputs to land before the first layer reads them
                if (!i_busy) begin
                    n_state = ST_LAYER;
                    n_layer = LY_FIRST;
                    n_i     = '0;
                    n_j     = '0;
                end
            end
            ST_LAYER: begin
                o_tok.valid  = 1'b1;
                o_tok.relu   = w_relu;
                o_tok.wr_act = !w_score;
                o_tok.score  = w_score;
                o_tok.bank   = w_dst;
                o_tok.idx    = IDX_W'(r_j);
                if (r_i == '0) begin
                    // bias step opens the neuron
                    o_tok.kind   = OP_BIAS;
                    o_coef_raddr = w_bofs + CAW'(r_j);
                    n_i          = CNT_W'(1);
                    n_waddr      = w_wofs + CAW'(r_j);
                end else begin
                    o_tok.kind = OP_MAC;
                    o_tok.last = w_last;
                    n_waddr    = r_waddr + CAW'(w_nout);
                    if (w_last) begin
                        n_i = '0;
                        if (r_j == w_nout - CNT_W'(1)) begin
                            n_j     = '0;
                            n_state = ST_DRAIN;
                        end else begin
                            n_j = r_j + CNT_W'(1);
                        end
                    end else begin
                        n_i = r_i + CNT_W'(1);
                    end
                end
            end
            ST_DRAIN: begin
                // let the layer's last results retire before the next layer reads
                if (!i_busy) begin
                    if (r_layer == LY_OUTPUT) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_LAYER;
                        n_layer = (r_layer == LY_FIRST) ? LY_SECOND : LY_OUTPUT;
                    end
                end
            end
            ST_FINISH: begin
                if (i_out_free) begin
                    o_finish = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
